FILE: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and index helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int MAX_ORDER  = 10;
   localparam int POOL_SIZE  = 1 << MAX_ORDER;
   localparam int MAP_SIZE   = 2 << MAX_ORDER;
   localparam int IDX_W      = MAX_ORDER + 1;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int RAM_DEPTH  = MAP_SIZE / WORD_W;
   localparam int RAM_AW     = $clog2(RAM_DEPTH);
   localparam int ORD_W      = 4;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD      = 2'd2
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_CARVE_SEL,
      S_DECODE,
      S_SRCH_ORD,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SPLIT_SEL,
      S_MERGE_SEL,
      S_MERGE_RD,
      S_MERGE_CHK,
      S_SET_RD,
      S_SET_WR,
      S_DONE
   } state_type;

   // first bit of order k in the flat map
   function automatic logic [IDX_W-1:0] order_lo(input logic [ORD_W-1:0] k);
      logic [IDX_W:0] v;
      v = (IDX_W+1)'(MAP_SIZE) - ((IDX_W+1)'(MAP_SIZE) >> k);
      return v[IDX_W-1:0];
   endfunction

   // last bit of order k in the flat map
   function automatic logic [IDX_W-1:0] order_hi(input logic [ORD_W-1:0] k);
      logic [IDX_W:0] v;
      v = (IDX_W+1)'(order_lo(k)) + ((IDX_W+1)'(POOL_SIZE) >> k) - (IDX_W+1)'(1);
      return v[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] map_index(input logic [ORD_W-1:0] k,
                                                  input logic [MAX_ORDER-1:0] off);
      logic [IDX_W-1:0] slot;
      slot = IDX_W'(off >> k);
      return order_lo(k) + slot;
   endfunction

   function automatic logic [ORD_W-1:0] ceil_log2(input logic [IDX_W-1:0] v);
      logic [ORD_W-1:0] r;
      r = '0;
      for (int i = IDX_W; i >= 0; i--) begin
         if (((IDX_W+1)'(1) << i) >= (IDX_W+1)'(v)) begin
            r = ORD_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [ORD_W-1:0] floor_log2(input logic [IDX_W-1:0] v);
      logic [ORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < IDX_W; i++) begin
         if (v[i]) begin
            r = ORD_W'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: src/bba_if.sv
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels carrying requests and responses of the allocator.
// ----------------------------------------------------------------------------
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [10:0] block_count;
   logic [9:0]  block_offset;

   modport source (output valid, output operation, output block_count,
                   output block_offset, input ready);
   modport sink   (input valid, input operation, input block_count,
                   input block_offset, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [9:0]  alloc_offset;
   logic [10:0] free_blocks;

   modport source (output valid, output status, output alloc_offset,
                   output free_blocks, input ready);
   modport sink   (input valid, input status, input alloc_offset,
                   input free_blocks, output ready);
endinterface

FILE: src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator; free bitmap per order held in a word RAM and
// walked by a small sequencer.
//
//   channel  | dir | handshake            | payload
//   req_ch   | in  | valid/ready          | operation, block_count, block_offset
//   rsp_ch   | out | valid/ready          | status, alloc_offset, free_blocks
//   csr_*    | in  | APB, pready tied hi  | useful_blocks at address 0
//
// Alloc: tries orders from the request's upward, scanning each order's
// bitmap words for a free block, then splits it down level by level. Free:
// merges with free buddies up to the top order, then inserts the block.
// Reset or a useful_blocks write: clearing pass over all 64 map words, then
// a carve setting one block per set bit of the count, req_ch.ready low throughout.
// One transfer in flight; a held response stalls only the final load.
// ----------------------------------------------------------------------------
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bba_req_if.sink     req_ch,
   bba_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    useful_ff, useful_in;
   logic [IDX_W-1:0]    total_ff, total_in;
   logic [ORD_W-1:0]    ord_ff, ord_in;
   logic [ORD_W-1:0]    k_ff, k_in;
   logic [MAX_ORDER-1:0] base_ff, base_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [RAM_AW-1:0]   word_ff, word_in;
   logic                op_ff, op_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [MAX_ORDER-1:0] off_ff, off_in;
   logic                carve_ff, carve_in;
   status_type          status_ff, status_in;
   logic [MAX_ORDER-1:0] result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [MAX_ORDER-1:0] rsp_offset_ff, rsp_offset_in;
   logic [IDX_W-1:0]    rsp_free_ff, rsp_free_in;

   logic                ram_we;
   logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
   logic [WORD_W-1:0]   ram_wdata, ram_rdata;

   logic                csr_wr;
   logic [IDX_W-1:0]    csr_val;
   logic [ORD_W-1:0]    top_order;
   logic [ORD_W-1:0]    req_k;
   logic                req_bad;
   logic [WORD_W-1:0]   hits;
   logic                hit_any;
   logic [BIT_W-1:0]    hit_pos;
   logic [IDX_W-1:0]    lo_cur, hi_cur;
   logic [IDX_W:0]      span_end;
   logic [MAX_ORDER-1:0] free_base;
   logic                out_free;

   bba_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(useful_ff);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_val    = (csr_pwdata[IDX_W-1:0] > IDX_W'(POOL_SIZE)) ? IDX_W'(POOL_SIZE)
                                                               : csr_pwdata[IDX_W-1:0];

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.alloc_offset = rsp_offset_ff;
   assign rsp_ch.free_blocks  = rsp_free_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign top_order = floor_log2(useful_ff);
   assign req_k     = ceil_log2(cnt_ff);
   assign req_bad   = (cnt_ff == '0) || (useful_ff == '0) || (req_k > top_order);
   assign free_base = off_ff & ~(MAX_ORDER'((IDX_W'(1) << req_k) - IDX_W'(1)));
   assign span_end  = (IDX_W+1)'(free_base) + ((IDX_W+1)'(1) << req_k);

   assign lo_cur = order_lo(ord_ff);
   assign hi_cur = order_hi(ord_ff);

   always_comb begin
      logic [IDX_W-1:0] g;
      for (int b = 0; b < WORD_W; b++) begin
         g = {word_ff, BIT_W'(b)};
         hits[b] = ram_rdata[b] && (g >= lo_cur) && (g <= hi_cur);
      end
   end

   always_comb begin
      hit_pos = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (hits[b]) begin
            hit_pos = BIT_W'(b);
         end
      end
   end
   assign hit_any = |hits;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_ch.valid) state_in = S_DECODE;
         S_CLEAR:     if (word_ff == RAM_AW'(RAM_DEPTH - 1)) state_in = S_CARVE_SEL;
         S_CARVE_SEL: begin
            if (ord_ff == '0) state_in = S_IDLE;
            else if (useful_ff[ord_ff - ORD_W'(1)]) state_in = S_SET_RD;
         end
         S_DECODE: begin
            if (req_bad) state_in = S_DONE;
            else if (op_ff == OP_ALLOC) state_in = S_SRCH_ORD;
            else if (span_end > (IDX_W+1)'(useful_ff)) state_in = S_DONE;
            else state_in = S_MERGE_SEL;
         end
         S_SRCH_ORD:  state_in = (ord_ff > top_order) ? S_DONE : S_SRCH_RD;
         S_SRCH_RD:   state_in = S_SRCH_CHK;
         S_SRCH_CHK: begin
            if (hit_any) state_in = S_SPLIT_SEL;
            else if (word_ff == hi_cur[IDX_W-1:BIT_W]) state_in = S_SRCH_ORD;
            else state_in = S_SRCH_RD;
         end
         S_SPLIT_SEL: state_in = (ord_ff > k_ff) ? S_SET_RD : S_DONE;
         S_MERGE_SEL: state_in = (ord_ff < top_order) ? S_MERGE_RD : S_SET_RD;
         S_MERGE_RD:  state_in = S_MERGE_CHK;
         S_MERGE_CHK: state_in = ram_rdata[idx_ff[BIT_W-1:0]] ? S_MERGE_SEL : S_SET_RD;
         S_SET_RD:    state_in = S_SET_WR;
         S_SET_WR: begin
            if (carve_ff) state_in = S_CARVE_SEL;
            else if (op_ff == OP_ALLOC) state_in = S_SPLIT_SEL;
            else state_in = S_DONE;
         end
         S_DONE:      if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
      if (csr_wr) state_in = S_CLEAR;
   end

   // datapath and RAM control
   always_comb begin
      useful_in     = useful_ff;
      total_in      = total_ff;
      ord_in        = ord_ff;
      k_in          = k_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      word_in       = word_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      off_in        = off_ff;
      carve_in      = carve_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[IDX_W-1:BIT_W];
      ram_wdata     = ram_rdata;
      ram_raddr     = (state_ff == S_SRCH_RD) ? word_ff : idx_ff[IDX_W-1:BIT_W];

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.operation;
               cnt_in    = req_ch.block_count;
               off_in    = req_ch.block_offset;
               status_in = ST_OK;
               result_in = '0;
               carve_in  = 1'b0;
            end
         end
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = word_ff;
            ram_wdata = '0;
            word_in   = word_ff + RAM_AW'(1);
            ord_in    = ORD_W'(MAX_ORDER + 1);
            base_in   = '0;
            total_in  = useful_ff;
            carve_in  = 1'b1;
         end
         S_CARVE_SEL: begin
            if (ord_ff != '0) begin
               ord_in = ord_ff - ORD_W'(1);
               if (useful_ff[ord_ff - ORD_W'(1)]) begin
                  idx_in  = map_index(ord_ff - ORD_W'(1), base_ff);
                  base_in = base_ff + MAX_ORDER'(IDX_W'(1) << (ord_ff - ORD_W'(1)));
               end
            end
         end
         S_DECODE: begin
            k_in   = req_k;
            ord_in = req_k;
            if (req_bad) begin
               status_in = ST_BAD;
            end else if (op_ff == OP_FREE) begin
               base_in = free_base;
               if (span_end > (IDX_W+1)'(useful_ff)) status_in = ST_BAD;
            end
         end
         S_SRCH_ORD: begin
            word_in = lo_cur[IDX_W-1:BIT_W];
            if (ord_ff > top_order) status_in = ST_NO_SPACE;
         end
         S_SRCH_RD: ;
         S_SRCH_CHK: begin
            if (hit_any) begin
               ram_we    = 1'b1;
               ram_waddr = word_ff;
               ram_wdata = ram_rdata & ~(WORD_W'(1) << hit_pos);
               base_in   = MAX_ORDER'(({word_ff, hit_pos} - lo_cur) << ord_ff);
            end else if (word_ff == hi_cur[IDX_W-1:BIT_W]) begin
               ord_in = ord_ff + ORD_W'(1);
            end else begin
               word_in = word_ff + RAM_AW'(1);
            end
         end
         S_SPLIT_SEL: begin
            if (ord_ff > k_ff) begin
               ord_in = ord_ff - ORD_W'(1);
               idx_in = map_index(ord_ff - ORD_W'(1),
                                  base_ff + MAX_ORDER'(IDX_W'(1) << (ord_ff - ORD_W'(1))));
            end else begin
               total_in  = total_ff - (IDX_W'(1) << k_ff);
               result_in = base_ff;
            end
         end
         S_MERGE_SEL: begin
            if (ord_ff < top_order) begin
               idx_in = map_index(ord_ff, base_ff ^ MAX_ORDER'(IDX_W'(1) << ord_ff));
            end else begin
               idx_in   = map_index(ord_ff, base_ff);
               total_in = total_ff + (IDX_W'(1) << ord_ff);
            end
         end
         S_MERGE_RD: ;
         S_MERGE_CHK: begin
            if (ram_rdata[idx_ff[BIT_W-1:0]]) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata & ~(WORD_W'(1) << idx_ff[BIT_W-1:0]);
               total_in  = total_ff - (IDX_W'(1) << ord_ff);
               base_in   = base_ff & ~MAX_ORDER'(IDX_W'(1) << ord_ff);
               ord_in    = ord_ff + ORD_W'(1);
            end else begin
               idx_in   = map_index(ord_ff, base_ff);
               total_in = total_ff + (IDX_W'(1) << ord_ff);
            end
         end
         S_SET_RD: ;
         S_SET_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (WORD_W'(1) << idx_ff[BIT_W-1:0]);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_offset_in = result_ff;
               rsp_free_in   = total_ff;
            end
         end
         default: ;
      endcase

      if (csr_wr) begin
         useful_in = csr_val;
         word_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         useful_ff    <= IDX_W'(POOL_SIZE);
         word_ff      <= '0;
         carve_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         useful_ff    <= useful_in;
         word_ff      <= word_in;
         carve_ff     <= carve_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff      <= total_in;
      ord_ff        <= ord_in;
      k_ff          <= k_in;
      base_ff       <= base_in;
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      cnt_ff        <= cnt_in;
      off_ff        <= off_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_free_ff   <= rsp_free_in;
   end

endmodule
